>>> src/sfx_pkg.sv
package sfx_pkg;

  localparam int WORD_W = 32;
  localparam int MAG_W  = 31;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_ZERO_DEN     = 2'd1,
    STATUS_NOT_BELOW_ONE = 2'd2
  } status_t;

  // Payload handed from one division cell to the next.
  typedef struct packed {
    logic              invert;
    status_t           status;
    logic [MAG_W-1:0]  rem;
    logic [MAG_W-1:0]  mag_d;
    logic [WORD_W-1:0] word;
  } stage_t;

endpackage

>>> src/sfx_prep.sv
module sfx_prep (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [sfx_pkg::WORD_W-1:0]    numerator,
  input  logic signed [sfx_pkg::WORD_W-1:0]    denominator,
  output logic                                 out_valid,
  output sfx_pkg::stage_t                      out_stage
);
  import sfx_pkg::*;

  logic              a_valid;
  logic              a_zero;
  logic [MAG_W-1:0]  a_num;
  logic [MAG_W-1:0]  a_den;

  logic              halve;
  logic [WORD_W-1:0] num_sum;
  logic [WORD_W-1:0] den_sum;
  logic [MAG_W-1:0]  num_h;
  logic [MAG_W-1:0]  den_h;

  logic              neg_n;
  logic              neg_d;
  logic [MAG_W-1:0]  mag_n;
  logic [MAG_W-1:0]  mag_d;
  stage_t            stage_next;

  // A value lies outside [-2^30, 2^30) exactly when its two top bits differ.
  // Adding one to a negative value before the shift makes the halving
  // truncate toward zero.
  always_comb begin
    halve   = (numerator[WORD_W-1] ^ numerator[WORD_W-2]) |
              (denominator[WORD_W-1] ^ denominator[WORD_W-2]);
    num_sum = numerator + {{(WORD_W-1){1'b0}}, numerator[WORD_W-1]};
    den_sum = denominator + {{(WORD_W-1){1'b0}}, denominator[WORD_W-1]};
    num_h   = halve ? num_sum[WORD_W-1:1] : numerator[MAG_W-1:0];
    den_h   = halve ? den_sum[WORD_W-1:1] : denominator[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
    if (en) begin
      a_zero <= (denominator == '0);
      a_num  <= num_h;
      a_den  <= den_h;
    end
  end

  always_comb begin
    neg_n = a_num[MAG_W-1];
    neg_d = a_den[MAG_W-1];
    mag_n = neg_n ? (~a_num + MAG_W'(1)) : a_num;
    mag_d = neg_d ? (~a_den + MAG_W'(1)) : a_den;
    stage_next.invert = neg_n ^ neg_d;
    stage_next.rem    = mag_n;
    stage_next.mag_d  = mag_d;
    stage_next.word   = '0;
    if (a_zero) begin
      stage_next.status = STATUS_ZERO_DEN;
    end else if ((mag_d == '0) || (mag_n >= mag_d)) begin
      stage_next.status = STATUS_NOT_BELOW_ONE;
    end else begin
      stage_next.status = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= a_valid;
    end
    if (en) begin
      out_stage <= stage_next;
    end
  end

endmodule

>>> src/sfx_cell.sv
module sfx_cell #(
  parameter int BIT_POS = 30
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  sfx_pkg::stage_t in_stage,
  output logic            out_valid,
  output sfx_pkg::stage_t out_stage
);
  import sfx_pkg::*;

  logic [MAG_W:0]   shifted;
  logic [MAG_W+1:0] diff;
  logic             take;
  stage_t           stage_next;

  // One restoring step: double the remainder and subtract the divisor if it fits.
  always_comb begin
    shifted    = {in_stage.rem, 1'b0};
    diff       = {1'b0, shifted} - {2'b00, in_stage.mag_d};
    take       = ~diff[MAG_W+1];
    stage_next = in_stage;
    stage_next.rem = take ? diff[MAG_W-1:0] : shifted[MAG_W-1:0];
    stage_next.word[BIT_POS] = take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_stage <= stage_next;
    end
  end

endmodule

>>> src/signed_fraction_to_fixed_point_unit.sv
// Signed fraction to fixed-point converter.
// The slave channel carries one operand pair per transaction: numerator in
// s_tdata[31:0] and denominator in s_tdata[63:32], both two's complement.
// The master channel returns one transaction per input: the fraction word in
// m_tdata and a status code in m_tuser (0 ok, 1 zero denominator, 2 magnitude
// not below one; the word is zero whenever the status is not ok).
// Two preparation stages (halving, then magnitudes and range check) are
// followed by a chain of FRACTION_BITS division cells, each producing one
// quotient bit per cycle while the chain advances.
// One transaction per cycle when not stalled; the whole chain moves together.
// When the receiver stalls with a result waiting, the chain freezes and
// s_tready drops in the same cycle; it returns as soon as m_tready is high.
// A synchronous reset empties the chain; no result is pending after it.
module signed_fraction_to_fixed_point_unit #(
  parameter int FRACTION_BITS = 31
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // numerator [31:0], denominator [63:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // fraction_word [31:0]
  output logic [1:0]  m_tuser    // status [1:0]
);
  import sfx_pkg::*;

  logic   adv;
  logic   valid [FRACTION_BITS+1];
  stage_t stage [FRACTION_BITS+1];
  stage_t last;

  assign adv      = ~m_tvalid | m_tready;
  assign s_tready = adv;

  sfx_prep u_prep (
    .clk         (clk),
    .rst         (rst),
    .en          (adv),
    .in_valid    (s_tvalid),
    .numerator   (s_tdata[WORD_W-1:0]),
    .denominator (s_tdata[2*WORD_W-1:WORD_W]),
    .out_valid   (valid[0]),
    .out_stage   (stage[0])
  );

  for (genvar k = 0; k < FRACTION_BITS; k++) begin : g_cell
    sfx_cell #(
      .BIT_POS (WORD_W - 2 - k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .in_valid  (valid[k]),
      .in_stage  (stage[k]),
      .out_valid (valid[k+1]),
      .out_stage (stage[k+1])
    );
  end

  assign last     = stage[FRACTION_BITS];
  assign m_tvalid = valid[FRACTION_BITS];
  assign m_tuser  = last.status;
  assign m_tdata  = (last.status == STATUS_OK) ?
                    (last.word ^ {WORD_W{last.invert}}) : '0;

endmodule

>>> src/sfx_checker.sv
module sfx_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser
);
  import sfx_pkg::*;

  // Nothing is pending straight after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result presented directly after reset");

  // The input side is held back only by a stalled result.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("s_tready does not follow the output stall");

  // Error results carry a zero word.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != STATUS_OK)) |-> (m_tdata == '0))
    else $error("error result with nonzero fraction word");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind signed_fraction_to_fixed_point_unit sfx_checker u_sfx_checker (.*);

>>> tb/sv/tb_signed_fraction_to_fixed_point_unit.sv
module tb_signed_fraction_to_fixed_point_unit;
  import sfx_pkg::*;

  localparam int FRACTION_BITS = 31;
  localparam int RANDOM_PER_PHASE = 150;
  localparam int DIRECTED_COUNT = 23;
  localparam int EDGE_COUNT = 12;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    status_t           status;
  } fraction_t;

  typedef struct packed {
    logic [31:0]       num;
    logic [31:0]       den;
    bit                known;
    logic [WORD_W-1:0] word;
    status_t           status;
  } directed_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;   // numerator [31:0], denominator [63:32]
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // fraction_word [31:0]
  logic [1:0]  m_tuser;   // status [1:0]

  fraction_t awaited_fractions[$];
  int        mismatches = 0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;
  int        holdoff_left = 0;

  // Rows with a typed result can be read straight off the definition; the others
  // go through the predictor.
  directed_row_t directed_rows [DIRECTED_COUNT] = '{
    '{32'h0000_0001, 32'h0000_0002, 1'b1, 32'h4000_0000, STATUS_OK},
    '{32'hFFFF_FFFF, 32'h0000_0002, 1'b1, 32'hBFFF_FFFF, STATUS_OK},
    '{32'h0000_0001, 32'hFFFF_FFFE, 1'b1, 32'hBFFF_FFFF, STATUS_OK},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1, 32'h4000_0000, STATUS_OK},
    '{32'h0000_0000, 32'h0000_0005, 1'b1, 32'h0000_0000, STATUS_OK},
    '{32'h0000_0000, 32'hFFFF_FFFB, 1'b1, 32'hFFFF_FFFF, STATUS_OK},
    '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, STATUS_OK},
    '{32'h0000_0005, 32'h0000_0000, 1'b1, 32'h0000_0000, STATUS_ZERO_DEN},
    '{32'h8000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, STATUS_ZERO_DEN},
    '{32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, STATUS_ZERO_DEN},
    '{32'h0000_0003, 32'h0000_0003, 1'b1, 32'h0000_0000, STATUS_NOT_BELOW_ONE},
    '{32'hFFFF_FFF9, 32'h0000_0003, 1'b1, 32'h0000_0000, STATUS_NOT_BELOW_ONE},
    '{32'h7FFF_FFFF, 32'h0000_0001, 1'b1, 32'h0000_0000, STATUS_NOT_BELOW_ONE},
    '{32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0000_0000, STATUS_NOT_BELOW_ONE},
    '{32'h4000_0001, 32'h4000_0000, 1'b1, 32'h0000_0000, STATUS_NOT_BELOW_ONE},
    '{32'h7FFF_FFFE, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000, STATUS_NOT_BELOW_ONE},
    '{32'hC000_0000, 32'h8000_0000, 1'b1, 32'h4000_0000, STATUS_OK},
    '{32'hFFFF_FFFF, 32'h8000_0000, 1'b1, 32'hFFFF_FFFF, STATUS_OK},
    '{32'h3FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000, STATUS_OK},
    '{32'h3FFF_FFFF, 32'h4000_0000, 1'b0, 32'h0000_0000, STATUS_OK},
    '{32'hBFFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000, STATUS_OK},
    '{32'h0000_0001, 32'h3FFF_FFFF, 1'b0, 32'h0000_0000, STATUS_OK},
    '{32'h3FFF_FFFE, 32'hC000_0001, 1'b0, 32'h0000_0000, STATUS_OK}
  };

  logic [31:0] edge_values [EDGE_COUNT] = '{
    32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0002,
    32'h3FFF_FFFF, 32'h4000_0000, 32'hC000_0000, 32'hBFFF_FFFF,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h4000_0001, 32'h8000_0001
  };

  signed_fraction_to_fixed_point_unit #(
    .FRACTION_BITS(FRACTION_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  function automatic fraction_t divide_fraction(logic [31:0] num_raw, logic [31:0] den_raw);
    longint    n;
    longint    d;
    longint    mag_n;
    longint    mag_d;
    longint    rem;
    fraction_t q;
    n = longint'($signed(num_raw));
    d = longint'($signed(den_raw));
    q.word = '0;
    q.status = STATUS_OK;
    if (d == 0) begin
      q.status = STATUS_ZERO_DEN;
      return q;
    end
    // Either operand beyond half the word range halves both, rounding to zero.
    if (n < -64'sh4000_0000 || n >= 64'sh4000_0000 ||
        d < -64'sh4000_0000 || d >= 64'sh4000_0000) begin
      n = n / 2;
      d = d / 2;
    end
    mag_n = (n < 0) ? -n : n;
    mag_d = (d < 0) ? -d : d;
    if (mag_d == 0 || mag_n >= mag_d) begin
      q.status = STATUS_NOT_BELOW_ONE;
      return q;
    end
    rem = mag_n;
    for (int i = 0; i < FRACTION_BITS; i++) begin
      rem = rem << 1;
      if (rem >= mag_d) begin
        rem = rem - mag_d;
        q.word[30-i] = 1'b1;
      end
    end
    if ((n < 0) != (d < 0)) q.word = ~q.word;
    return q;
  endfunction

  function automatic logic [31:0] with_sign(logic [31:0] mag, bit negative);
    return negative ? -mag : mag;
  endfunction

  task automatic pick_operands(output logic [31:0] n, output logic [31:0] d);
    logic [31:0] mag_n;
    logic [31:0] mag_d;
    int unsigned kind;
    kind = $urandom_range(9);
    case (kind)
      0, 1, 2: begin
        n = $urandom;
        d = $urandom;
      end
      3, 4, 5: begin
        // Proper fractions inside the unhalved range, spread over all sizes.
        mag_d = ($urandom >> $urandom_range(31, 2)) | 32'd1;
        mag_n = $urandom % mag_d;
        n = with_sign(mag_n, 1'($urandom_range(1)));
        d = with_sign(mag_d, 1'($urandom_range(1)));
      end
      6: begin
        n = $urandom;
        d = '0;
      end
      7: begin
        n = edge_values[$urandom_range(EDGE_COUNT-1)];
        d = edge_values[$urandom_range(EDGE_COUNT-1)];
      end
      8: begin
        mag_d = $urandom_range(32'h7FFF_FFFF, 32'h4000_0000);
        mag_n = $urandom % mag_d;
        n = with_sign(mag_n, 1'($urandom_range(1)));
        d = with_sign(mag_d, 1'($urandom_range(1)));
      end
      default: begin
        // Magnitudes close to each other sit on the boundary of the range check.
        mag_d = ($urandom >> $urandom_range(31, 1)) | 32'd1;
        mag_n = mag_d + $urandom_range(2) - 1;
        n = with_sign(mag_n, 1'($urandom_range(1)));
        d = with_sign(mag_d, 1'($urandom_range(1)));
      end
    endcase
  endtask

  task automatic send_operands(input logic [31:0] n, input logic [31:0] d,
                               input fraction_t expected);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {d, n};
    do @(posedge clk); while (!s_tready);
    awaited_fractions.push_back(expected);
  endtask

  task automatic send_random(input int count);
    logic [31:0] n;
    logic [31:0] d;
    for (int i = 0; i < count; i++) begin
      pick_operands(n, d);
      send_operands(n, d, divide_fraction(n, d));
    end
  endtask

  // The sender holds back until every outstanding transaction has returned.
  task automatic drain;
    s_tvalid <= 1'b0;
    while (awaited_fractions.size() != 0) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver: checks each transaction on the master side, then decides on stalling.
  initial begin
    fraction_t exp;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (awaited_fractions.size() == 0) begin
          $error("result with nothing awaited: fraction_word %h status %0d", m_tdata, m_tuser);
          mismatches++;
        end else begin
          exp = awaited_fractions.pop_front();
          if (m_tdata !== exp.word) begin
            $error("fraction_word: expected %h, actual %h", exp.word, m_tdata);
            mismatches++;
          end
          if (m_tuser !== exp.status) begin
            $error("status: expected %0d, actual %0d", exp.status, m_tuser);
            mismatches++;
          end
        end
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    directed_row_t row;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_operands(row.num, row.den,
                    row.known ? fraction_t'({row.word, row.status})
                              : divide_fraction(row.num, row.den));
    end
    drain();

    send_random(RANDOM_PER_PHASE);
    drain();

    send_idle_pct = 84;
    send_random(RANDOM_PER_PHASE);
    drain();

    send_idle_pct = 0;
    stall_pct = 84;
    send_random(RANDOM_PER_PHASE);
    drain();

    send_idle_pct = 24;
    stall_pct = 24;
    send_random(RANDOM_PER_PHASE);
    drain();

    // A long hold-off on the receiver lets the chain fill and stall the sender.
    send_idle_pct = 0;
    stall_pct = 0;
    holdoff_left = 300;
    send_random(RANDOM_PER_PHASE);
    drain();

    repeat (FRACTION_BITS + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
src/sfx_pkg.sv
src/sfx_prep.sv
src/sfx_cell.sv
src/signed_fraction_to_fixed_point_unit.sv
src/sfx_checker.sv
tb/sv/tb_signed_fraction_to_fixed_point_unit.sv
